// ===== hw/rtl/html_href_link_extractor_top_macros.svh =====
// Assertion macros used by the result queue (hhle_out_fifo.sv).
`ifndef HTML_HREF_LINK_EXTRACTOR_TOP_MACROS_SVH
`define HTML_HREF_LINK_EXTRACTOR_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define HHLE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define HHLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/hhle_pkg.sv =====
package hhle_pkg;

  localparam int MaxUrlBytes = 1024;
  localparam int CntW        = $clog2(MaxUrlBytes);
  localparam int LenW        = 10;
  localparam int TagLen      = 2;
  localparam int AttrLen     = 6;

  localparam int FifoDepth   = 4;
  localparam int FifoPtrW    = $clog2(FifoDepth);
  localparam int FifoCntW    = $clog2(FifoDepth + 1);

  localparam logic [7:0] DocEnd   = 8'h00;
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChClose  = 8'h3E;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChWsLo   = 8'h09;
  localparam logic [7:0] ChWsHi   = 8'h0D;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ABORT = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    PH_SEARCH  = 3'b001,
    PH_LEAD    = 3'b010,
    PH_CAPTURE = 3'b100
  } phase_t;

  typedef struct packed {
    kind_t            kind;
    logic [7:0]       url_byte;
    logic [LenW-1:0]  url_len;
  } result_t;

  // up to two results from one document byte
  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } res_pair_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == ChSpace) || (c >= ChWsLo && c <= ChWsHi);
  endfunction

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
  endfunction

  function automatic logic [7:0] tag_char(input logic [1:0] idx);
    logic [7:0] ch;
    unique case (idx)
      2'd0:    ch = 8'h3C; // '<'
      default: ch = 8'h61; // 'a'
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] attr_char(input logic [2:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0:    ch = 8'h68; // h
      3'd1:    ch = 8'h72; // r
      3'd2:    ch = 8'h65; // e
      3'd3:    ch = 8'h66; // f
      3'd4:    ch = 8'h3D; // =
      default: ch = ChQuote;
    endcase
    return ch;
  endfunction

  function automatic result_t mk_byte(input logic [7:0] b);
    result_t r;
    r.kind     = KIND_BYTE;
    r.url_byte = b;
    r.url_len  = '0;
    return r;
  endfunction

  function automatic result_t mk_done(input logic [LenW-1:0] len);
    result_t r;
    r.kind     = KIND_DONE;
    r.url_byte = '0;
    r.url_len  = len;
    return r;
  endfunction

  function automatic result_t mk_abort();
    result_t r;
    r.kind     = KIND_ABORT;
    r.url_byte = '0;
    r.url_len  = '0;
    return r;
  endfunction

endpackage

// ===== hw/rtl/hhle_parser.sv =====
module hhle_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [7:0]          doc_byte,
  output hhle_pkg::res_pair_t pair
);

  logic                      vld_r;
  logic [7:0]                byte_r;

  logic [1:0]                tag_r, tag_nxt;
  logic                      anc_r, anc_nxt;
  logic [2:0]                attr_r, attr_nxt;
  hhle_pkg::phase_t          phase_r, phase_nxt;
  logic [7:0]                held_r, held_nxt;
  logic                      hv_r, hv_nxt;
  logic [hhle_pkg::CntW-1:0] cnt_r, cnt_nxt;
  logic                      trunc_r, trunc_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= accept;
    end
    if (accept) begin
      byte_r <= doc_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r   <= '0;
      anc_r   <= 1'b0;
      attr_r  <= '0;
      phase_r <= hhle_pkg::PH_SEARCH;
      held_r  <= '0;
      hv_r    <= 1'b0;
      cnt_r   <= '0;
      trunc_r <= 1'b0;
    end else begin
      tag_r   <= tag_nxt;
      anc_r   <= anc_nxt;
      attr_r  <= attr_nxt;
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
      hv_r    <= hv_nxt;
      cnt_r   <= cnt_nxt;
      trunc_r <= trunc_nxt;
    end
  end

  always_comb begin
    logic [7:0]                lc;
    logic                      ws;
    logic [hhle_pkg::CntW-1:0] len;

    tag_nxt   = tag_r;
    anc_nxt   = anc_r;
    attr_nxt  = attr_r;
    phase_nxt = phase_r;
    held_nxt  = held_r;
    hv_nxt    = hv_r;
    cnt_nxt   = cnt_r;
    trunc_nxt = trunc_r;
    pair.n    = 2'd0;
    pair.r0   = hhle_pkg::mk_abort();
    pair.r1   = hhle_pkg::mk_abort();
    ws        = hhle_pkg::is_ws(byte_r);
    lc        = hhle_pkg::fold_case(byte_r);
    len       = cnt_r;

    if (vld_r) begin
      if (byte_r == hhle_pkg::DocEnd || ((byte_r == hhle_pkg::ChQuote || ws) &&
          phase_r != hhle_pkg::PH_SEARCH && !(ws && phase_r == hhle_pkg::PH_LEAD))) begin
        // document end or URL terminator: report any open URL and restart parsing
        if (byte_r == hhle_pkg::DocEnd) begin
          if (phase_r != hhle_pkg::PH_SEARCH) begin
            pair.n  = 2'd1;
            pair.r0 = hhle_pkg::mk_abort();
          end
        end else if (hv_r && (trunc_r || held_r != hhle_pkg::ChSlash)) begin
          pair.n  = 2'd2;
          pair.r0 = hhle_pkg::mk_byte(held_r);
          pair.r1 = hhle_pkg::mk_done(hhle_pkg::LenW'(len));
        end else begin
          if (hv_r) begin
            len = cnt_r - 1'b1;
          end
          pair.n  = 2'd1;
          pair.r0 = hhle_pkg::mk_done(hhle_pkg::LenW'(len));
        end
        tag_nxt   = '0;
        anc_nxt   = 1'b0;
        attr_nxt  = '0;
        phase_nxt = hhle_pkg::PH_SEARCH;
        held_nxt  = '0;
        hv_nxt    = 1'b0;
        cnt_nxt   = '0;
        trunc_nxt = 1'b0;
      end else if (phase_r != hhle_pkg::PH_SEARCH) begin
        if (!ws) begin
          phase_nxt = hhle_pkg::PH_CAPTURE;
          if (cnt_r >= hhle_pkg::CntW'(hhle_pkg::MaxUrlBytes - 1)) begin
            trunc_nxt = 1'b1;
          end else begin
            if (hv_r) begin
              pair.n  = 2'd1;
              pair.r0 = hhle_pkg::mk_byte(held_r);
            end
            held_nxt = byte_r;
            hv_nxt   = 1'b1;
            cnt_nxt  = cnt_r + 1'b1;
          end
        end
      end else if (!ws) begin
        if (!anc_r && tag_r < 2'(hhle_pkg::TagLen) && lc == hhle_pkg::tag_char(tag_r)) begin
          tag_nxt = tag_r + 1'b1;
          if (tag_r == 2'(hhle_pkg::TagLen - 1)) begin
            anc_nxt = 1'b1;
          end
        end else begin
          tag_nxt = '0;
        end

        if (anc_nxt && lc == hhle_pkg::ChClose) begin
          anc_nxt = 1'b0;
          tag_nxt = '0;
        end

        if (anc_nxt && attr_r < 3'(hhle_pkg::AttrLen) && lc == hhle_pkg::attr_char(attr_r)) begin
          if (attr_r == 3'(hhle_pkg::AttrLen - 1)) begin
            attr_nxt  = '0;
            tag_nxt   = '0;
            anc_nxt   = 1'b0;
            phase_nxt = hhle_pkg::PH_LEAD;
            hv_nxt    = 1'b0;
            held_nxt  = '0;
            cnt_nxt   = '0;
            trunc_nxt = 1'b0;
          end else begin
            attr_nxt = attr_r + 1'b1;
          end
        end else begin
          attr_nxt = '0;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/hhle_out_fifo.sv =====
`include "html_href_link_extractor_top_macros.svh"

module hhle_out_fifo (
  input  logic                              clk,
  input  logic                              rst_n,
  input  hhle_pkg::res_pair_t               pair,
  output logic [hhle_pkg::FifoCntW-1:0]     count,
  output logic                              out_valid,
  input  logic                              out_stall,
  output hhle_pkg::result_t                 out_res
);

  hhle_pkg::result_t                mem [hhle_pkg::FifoDepth];
  logic [hhle_pkg::FifoPtrW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [hhle_pkg::FifoPtrW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [hhle_pkg::FifoCntW-1:0]    count_r, count_nxt;
  logic                             rd;

  assign out_valid = (count_r != '0);
  assign out_res   = mem[rd_ptr_r];
  assign count     = count_r;
  assign rd        = out_valid && !out_stall;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + hhle_pkg::FifoPtrW'(pair.n);
    rd_ptr_nxt = rd_ptr_r + hhle_pkg::FifoPtrW'(rd);
    count_nxt  = count_r + hhle_pkg::FifoCntW'(pair.n) - hhle_pkg::FifoCntW'(rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pair.n != 2'd0) begin
      mem[wr_ptr_r] <= pair.r0;
    end
    if (pair.n == 2'd2) begin
      mem[wr_ptr_r + 1'b1] <= pair.r1;
    end
  end

  `HHLE_ASSERT_NOW(a_no_overflow, pair.n != 2'd0,
    (32'(count_r) + 32'(pair.n)) <= hhle_pkg::FifoDepth, "result queue overflow")
  `HHLE_ASSERT_NOW(a_pair_count, 1'b1, pair.n != 2'd3, "more than two results in one cycle")
  `HHLE_ASSERT_NEXT(a_empty_stays, count_r == '0 && pair.n == 2'd0, !out_valid,
    "result appeared without a write")
  `HHLE_ASSERT_NEXT(a_ptr_gap, 1'b1,
    count_r == '0 || count_r == hhle_pkg::FifoCntW'(hhle_pkg::FifoDepth) ||
    hhle_pkg::FifoPtrW'(count_r) == (wr_ptr_r - rd_ptr_r), "queue pointers disagree with count")

endmodule

// ===== hw/rtl/html_href_link_extractor_top.sv =====
// Anchor href extractor.
// Input channel: one HTML document byte per transfer (in_valid/in_stall,
// in_doc_byte). A byte of 0 ends the document and resets the parser.
// Result channel: out_valid/out_stall with out_kind, out_url_byte and
// out_url_len. Kind 0 carries one URL byte, kind 1 marks a finished URL
// with its length, kind 2 marks a URL cut off by the document end.
// A transferred byte is registered and parsed in the following cycle; the
// results it gives are written into the result queue and offered from there.
// Throughput: one byte per cycle while in_stall is low. The byte that ends
// a URL can give two results; a four-entry result queue absorbs them, and
// in_stall rises when the queue plus the byte being parsed would leave less
// than two free slots, so a two-result byte meeting a non-empty queue stalls
// the input.
// Receiver stall backs up the queue and then holds the input; nothing is lost.
// Reset (rst_n low, synchronous) empties the queue and returns the parser to
// searching for an anchor tag.
module html_href_link_extractor_top (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [7:0]                in_doc_byte,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                out_kind,
  output logic [7:0]                out_url_byte,
  output logic [hhle_pkg::LenW-1:0] out_url_len
);

  hhle_pkg::res_pair_t              pair;
  hhle_pkg::result_t                out_res;
  logic [hhle_pkg::FifoCntW-1:0]    count;
  logic [hhle_pkg::FifoCntW:0]      need;
  logic                             accept;

  // room needed once the byte now being parsed has been written
  assign need     = (hhle_pkg::FifoCntW + 1)'(count) + (hhle_pkg::FifoCntW + 1)'(pair.n);
  assign in_stall = need > (hhle_pkg::FifoCntW + 1)'(hhle_pkg::FifoDepth - 2);
  assign accept   = in_valid && !in_stall;

  hhle_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .doc_byte (in_doc_byte),
    .pair     (pair)
  );

  hhle_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .pair      (pair),
    .count     (count),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_kind     = out_res.kind;
  assign out_url_byte = out_res.url_byte;
  assign out_url_len  = out_res.url_len;

endmodule
